### hdl/asset_metadata_deframer_macros.svh
// Assertion macros for the asset metadata deframer.
`ifndef ASSET_METADATA_DEFRAMER_MACROS_SVH
`define ASSET_METADATA_DEFRAMER_MACROS_SVH

// Same-cycle implication, held off during reset.
`define AMD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, held off during reset.
`define AMD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/amd_pkg.sv
// Types, constants and helpers for the asset metadata deframer.
package amd_pkg;

	localparam int unsigned TXID_BYTES  = 32;
	localparam int unsigned TXID_ROWS   = TXID_BYTES / 8;
	localparam int unsigned ROW_AW      = $clog2(TXID_ROWS);
	localparam int unsigned LANE_AW     = 3;
	localparam int unsigned BURST_CW    = $clog2(TXID_ROWS + 1);
	localparam int unsigned INDEX_BYTES = 4;

	localparam logic [7:0] LEN_SHORT_MAX = 8'hfc;
	localparam logic [7:0] LEN_PFX_16    = 8'hfd;
	localparam logic [7:0] LEN_PFX_32    = 8'hfe;
	localparam logic [2:0] LEN_BYTES_16  = 3'd2;
	localparam logic [2:0] LEN_BYTES_32  = 3'd4;

	typedef enum logic [2:0] {
		ST_LEN      = 3'd0,
		ST_CONTRACT = 3'd1,
		ST_TXID     = 3'd2,
		ST_INDEX    = 3'd3,
		ST_FINISH   = 3'd4,
		ST_ERROR    = 3'd5
	} stage_t;

	typedef enum logic [1:0] {
		KIND_CONTRACT = 2'd0,
		KIND_TXID     = 2'd1,
		KIND_INDEX    = 2'd2,
		KIND_ERROR    = 2'd3
	} kind_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       restart;
	} in_item_t;

	typedef struct packed {
		kind_t       kind;
		logic [63:0] value;
		logic        last;
	} out_item_t;

	// Reverse the byte order of a 64-bit word.
	function automatic logic [63:0] byte_swap64(input logic [63:0] w);
		logic [63:0] r;
		r = '0;
		for (int j = 0; j < 8; j++) begin
			r[8*j +: 8] = w[8*(7-j) +: 8];
		end
		return r;
	endfunction

endpackage

### hdl/asset_metadata_deframer.sv
// Asset metadata deframer: takes the metadata stream one byte per cycle
// while data_ready is high and splits it into length, contract bytes,
// previous txid and output index. A contract byte or a format error gives
// one registered result. The 32 txid bytes are written one a cycle as taken
// into a 4 x 64-bit byte-writable RAM with a registered read. After the
// last index byte the block emits four reversed txid words from the RAM
// read port, then the index, one result per cycle while the skid stage is
// empty; input is held off until the burst ends. A result register backed
// by a skid stage lets input carry on while one result waits. After finish
// or error, bytes are taken and dropped until a restart.
`include "asset_metadata_deframer_macros.svh"

module asset_metadata_deframer (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               data_valid,
	output logic               data_ready,
	input  amd_pkg::in_item_t  data,
	output logic               res_valid,
	input  logic               res_ready,
	output amd_pkg::out_item_t res
);
	import amd_pkg::*;

	// stream parse state
	stage_t      stage_q, stage_d;
	logic [31:0] clen_q, clen_d;
	logic [31:0] bcnt_q, bcnt_d;
	logic [31:0] idx_q, idx_d;
	logic [2:0]  lbl_q, lbl_d;

	logic        accept;
	logic [7:0]  b;
	logic        first_ok;
	logic [31:0] mb_word;
	logic [2:0]  lbl_dec;
	logic [31:0] bcnt_inc;
	logic        len_err;
	logic        idx_done;
	logic        start_burst;

	// txid RAM
	logic [63:0]       txid_mem [TXID_ROWS];
	logic              txid_we;
	logic [ROW_AW-1:0] wr_row;
	logic [LANE_AW-1:0] wr_lane;
	logic [ROW_AW-1:0] rd_row;
	logic [63:0]       rd_word_q;

	// emit sequencer
	logic                burst_q, burst_d;
	logic [BURST_CW-1:0] burst_cnt_q, burst_cnt_d;
	logic                burst_adv;
	logic                burst_end;

	// result register and skid stage
	logic      push_valid;
	out_item_t push_item;
	logic      res_valid_q;
	out_item_t res_q;
	logic      skid_valid_q;
	out_item_t skid_q;

	assign data_ready = !skid_valid_q && !burst_q;
	assign accept     = data_valid && data_ready;
	assign b          = data.data_byte;

	assign first_ok    = (b != 8'd0) && (b <= LEN_SHORT_MAX);
	assign mb_word     = {clen_q[23:0], b};
	assign lbl_dec     = lbl_q - 3'd1;
	assign bcnt_inc    = bcnt_q + 32'd1;
	assign idx_done    = bcnt_inc >= 32'(INDEX_BYTES);
	assign len_err     = (bcnt_q == 32'd0)
		? !(first_ok || b == LEN_PFX_16 || b == LEN_PFX_32)
		: (lbl_dec == 3'd0 && mb_word == 32'd0);
	assign start_burst = accept && !data.restart && stage_q == ST_INDEX && idx_done;

	// next state
	always_comb begin
		stage_d = stage_q;
		clen_d  = clen_q;
		bcnt_d  = bcnt_q;
		idx_d   = idx_q;
		lbl_d   = lbl_q;
		if (accept) begin
			if (data.restart) begin
				stage_d = ST_LEN;
				clen_d  = '0;
				bcnt_d  = '0;
				idx_d   = '0;
				lbl_d   = '0;
			end else begin
				case (stage_q)
					ST_LEN: begin
						if (bcnt_q == 32'd0) begin
							bcnt_d = 32'd1;
							if (first_ok) begin
								clen_d  = {24'd0, b};
								stage_d = ST_CONTRACT;
								bcnt_d  = '0;
							end else if (b == LEN_PFX_16) begin
								lbl_d = LEN_BYTES_16;
							end else if (b == LEN_PFX_32) begin
								lbl_d = LEN_BYTES_32;
							end else begin
								stage_d = ST_ERROR;
								bcnt_d  = '0;
							end
						end else begin
							// extra length bytes, most significant first
							clen_d = mb_word;
							lbl_d  = lbl_dec;
							if (lbl_dec == 3'd0) begin
								bcnt_d  = '0;
								stage_d = (mb_word == 32'd0) ? ST_ERROR : ST_CONTRACT;
							end
						end
					end
					ST_CONTRACT: begin
						bcnt_d = bcnt_inc;
						if (bcnt_inc >= clen_q) begin
							stage_d = ST_TXID;
							bcnt_d  = '0;
						end
					end
					ST_TXID: begin
						bcnt_d = bcnt_inc;
						if (bcnt_inc >= 32'(TXID_BYTES)) begin
							stage_d = ST_INDEX;
							bcnt_d  = '0;
						end
					end
					ST_INDEX: begin
						idx_d  = idx_q | ({24'd0, b} << {bcnt_q[1:0], 3'b000});
						bcnt_d = bcnt_inc;
						if (idx_done) begin
							stage_d = ST_FINISH;
							bcnt_d  = '0;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q <= ST_LEN;
			clen_q  <= '0;
			bcnt_q  <= '0;
			idx_q   <= '0;
			lbl_q   <= '0;
		end else begin
			stage_q <= stage_d;
			clen_q  <= clen_d;
			bcnt_q  <= bcnt_d;
			idx_q   <= idx_d;
			lbl_q   <= lbl_d;
		end
	end

	// txid RAM: byte writes in arrival order, one row read per cycle
	assign txid_we = accept && !data.restart && stage_q == ST_TXID;
	assign wr_row  = bcnt_q[LANE_AW +: ROW_AW];
	assign wr_lane = bcnt_q[LANE_AW-1:0];
	// address from the next count so the data lines up with burst_cnt_q
	assign rd_row  = ROW_AW'(TXID_ROWS - 1) - burst_cnt_d[ROW_AW-1:0];

	always_ff @(posedge clk) begin
		if (txid_we) begin
			txid_mem[wr_row][{wr_lane, 3'b000} +: 8] <= b;
		end
		rd_word_q <= txid_mem[rd_row];
	end

	// emit sequencer: TXID_ROWS words, then the index
	assign burst_adv = burst_q && !skid_valid_q;
	assign burst_end = burst_cnt_q == BURST_CW'(TXID_ROWS);

	always_comb begin
		burst_d     = burst_q;
		burst_cnt_d = burst_cnt_q;
		if (start_burst) begin
			burst_d = 1'b1;
		end else if (burst_adv) begin
			if (burst_end) begin
				burst_d     = 1'b0;
				burst_cnt_d = '0;
			end else begin
				burst_cnt_d = burst_cnt_q + BURST_CW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			burst_q     <= 1'b0;
			burst_cnt_q <= '0;
		end else begin
			burst_q     <= burst_d;
			burst_cnt_q <= burst_cnt_d;
		end
	end

	// results
	always_comb begin
		push_valid      = 1'b0;
		push_item.kind  = KIND_CONTRACT;
		push_item.value = '0;
		push_item.last  = 1'b1;
		if (burst_adv) begin
			push_valid = 1'b1;
			if (burst_end) begin
				push_item.kind  = KIND_INDEX;
				push_item.value = {32'd0, idx_q};
			end else begin
				push_item.kind  = KIND_TXID;
				push_item.value = byte_swap64(rd_word_q);
				push_item.last  = 1'b0;
			end
		end else if (accept && !data.restart) begin
			case (stage_q)
				ST_LEN: begin
					if (len_err) begin
						push_valid     = 1'b1;
						push_item.kind = KIND_ERROR;
					end
				end
				ST_CONTRACT: begin
					push_valid      = 1'b1;
					push_item.value = {56'd0, b};
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!res_valid_q || res_ready) begin
			if (skid_valid_q) begin
				res_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				res_valid_q <= push_valid;
			end
		end else if (push_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!res_valid_q || res_ready) begin
			if (skid_valid_q) begin
				res_q <= skid_q;
			end else if (push_valid) begin
				res_q <= push_item;
			end
		end else if (push_valid) begin
			skid_q <= push_item;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	`AMD_ASSERT_NOW(a_skid_behind_res, skid_valid_q, res_valid_q,
		"skid full with result register empty")
	`AMD_ASSERT_NOW(a_no_input_in_burst, burst_q, !data_ready,
		"input taken during txid burst")
	`AMD_ASSERT_NOW(a_burst_cnt_range, burst_q, burst_cnt_q <= BURST_CW'(TXID_ROWS),
		"burst count out of range")
	`AMD_ASSERT_NEXT(a_burst_after_index, start_burst, burst_q && stage_q == ST_FINISH,
		"burst not started on index end")

endmodule
